// ===== rtl/core/sfdc_pkg.sv =====
// Shared types and constants for the serial frame deframer.
package sfdc_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_VER     = 3'd2,
        PH_CMD     = 3'd3,
        PH_LENH    = 3'd4,
        PH_LENL    = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_CSUM    = 3'd7
    } phase_t;

    localparam logic [7:0]  START_BYTE        = 8'h55;
    localparam logic [7:0]  SECOND_HDR_BYTE   = 8'hAA;
    localparam logic [7:0]  CMD_RECORD_REPORT = 8'h08;
    localparam logic [7:0]  DP_BATTERY        = 8'h0B;
    localparam logic [15:0] DP_OFFSET         = 16'd7;
    localparam logic [15:0] DP_MIN_LENGTH     = 16'd8;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  command;
        logic [7:0]  version;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [15:0] frame_length;
        logic        frame_ok;
        logic        header_bad;
        logic        checksum_bad;
        logic        battery_update;
        logic [7:0]  battery_value;
    } result_t;

endpackage

// ===== rtl/core/sfdc_parser.sv =====
// Frame parser: per-byte state update and result formation.
module sfdc_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  beat,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output sfdc_pkg::result_t     res
);

    sfdc_pkg::phase_t phase_reg, phase_next;
    logic        hdr_good_reg, hdr_good_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  dp_id_reg, dp_id_next;
    logic [7:0]  last_reg, last_next;
    logic [7:0]  battery_reg, battery_next;

    logic [15:0] count_inc;
    logic [15:0] length_full;
    logic        csum_bad;
    logic        hdr_bad;
    logic        frame_ok;
    logic        upd;

    assign count_inc   = count_reg + 16'd1;
    assign length_full = {length_reg[15:8], rx_byte};
    assign csum_bad    = (rx_byte != sum_reg);
    assign hdr_bad     = !hdr_good_reg;
    assign frame_ok    = !csum_bad && !hdr_bad;
    assign upd         = frame_ok && (command_reg == sfdc_pkg::CMD_RECORD_REPORT)
                         && (length_reg >= sfdc_pkg::DP_MIN_LENGTH)
                         && (dp_id_reg == sfdc_pkg::DP_BATTERY)
                         && (last_reg != battery_reg);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (beat)
        begin
            case (phase_reg)
                sfdc_pkg::PH_HUNT:
                    if (rx_byte == sfdc_pkg::START_BYTE)
                        phase_next = sfdc_pkg::PH_HDR2;
                sfdc_pkg::PH_HDR2:    phase_next = sfdc_pkg::PH_VER;
                sfdc_pkg::PH_VER:     phase_next = sfdc_pkg::PH_CMD;
                sfdc_pkg::PH_CMD:     phase_next = sfdc_pkg::PH_LENH;
                sfdc_pkg::PH_LENH:    phase_next = sfdc_pkg::PH_LENL;
                sfdc_pkg::PH_LENL:
                    phase_next = (length_full == 16'd0) ? sfdc_pkg::PH_CSUM
                                                        : sfdc_pkg::PH_PAYLOAD;
                sfdc_pkg::PH_PAYLOAD:
                    if (count_inc == length_reg)
                        phase_next = sfdc_pkg::PH_CSUM;
                default:              phase_next = sfdc_pkg::PH_HUNT;
            endcase
        end
    end

    // frame fields and result
    always_comb
    begin
        hdr_good_next = hdr_good_reg;
        version_next  = version_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        dp_id_next    = dp_id_reg;
        last_next     = last_reg;
        battery_next  = battery_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.command       = command_reg;
        res.version       = version_reg;
        res.frame_length  = length_reg;
        res.battery_value = battery_reg;
        if (beat)
        begin
            case (phase_reg)
                sfdc_pkg::PH_HUNT:
                    if (rx_byte == sfdc_pkg::START_BYTE)
                    begin
                        sum_next      = rx_byte;
                        hdr_good_next = 1'b0;
                        version_next  = '0;
                        command_next  = '0;
                        length_next   = '0;
                        count_next    = '0;
                        dp_id_next    = '0;
                        last_next     = '0;
                    end
                sfdc_pkg::PH_HDR2:
                begin
                    hdr_good_next = (rx_byte == sfdc_pkg::SECOND_HDR_BYTE);
                    sum_next      = sum_reg + rx_byte;
                end
                sfdc_pkg::PH_VER:
                begin
                    version_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                end
                sfdc_pkg::PH_CMD:
                begin
                    command_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                end
                sfdc_pkg::PH_LENH:
                begin
                    length_next = {rx_byte, 8'h00};
                    sum_next    = sum_reg + rx_byte;
                end
                sfdc_pkg::PH_LENL:
                begin
                    length_next = length_full;
                    count_next  = '0;
                    sum_next    = sum_reg + rx_byte;
                end
                sfdc_pkg::PH_PAYLOAD:
                begin
                    sum_next   = sum_reg + rx_byte;
                    last_next  = rx_byte;
                    count_next = count_inc;
                    if (count_reg == sfdc_pkg::DP_OFFSET)
                        dp_id_next = rx_byte;
                    res_valid         = 1'b1;
                    res.kind          = sfdc_pkg::KIND_PAYLOAD;
                    res.payload_byte  = rx_byte;
                    res.payload_index = count_reg;
                end
                default:
                begin
                    if (upd)
                        battery_next = last_reg;
                    res_valid          = 1'b1;
                    res.kind           = sfdc_pkg::KIND_SUMMARY;
                    res.frame_ok       = frame_ok;
                    res.header_bad     = hdr_bad;
                    res.checksum_bad   = csum_bad;
                    res.battery_update = upd;
                    res.battery_value  = battery_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= sfdc_pkg::PH_HUNT;
            hdr_good_reg <= 1'b0;
            version_reg  <= '0;
            command_reg  <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            dp_id_reg    <= '0;
            last_reg     <= '0;
            battery_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_good_reg <= hdr_good_next;
            version_reg  <= version_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            dp_id_reg    <= dp_id_next;
            last_reg     <= last_next;
            battery_reg  <= battery_next;
        end
    end

endmodule

// ===== rtl/core/sfdc_out_buf.sv =====
// Two-entry result buffer between the parser and the output channel.
module sfdc_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sfdc_pkg::result_t  push_data,
    output logic               has_room,
    output logic               out_valid,
    input  logic               out_ready,
    output sfdc_pkg::result_t  out_data
);

    sfdc_pkg::result_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign has_room  = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/serial_frame_deframer_checksum.sv =====
// Top level of the serial frame deframer with 8-bit additive checksum.
// Takes one received byte per beat and parses frames of the form
// 0x55 0xAA version command len_hi len_lo payload[len] checksum, where the
// checksum is the 8-bit sum of all earlier frame bytes. Bytes outside a frame
// are dropped until a 0x55 start byte shows up. Each payload byte yields one
// result beat (kind 0) with its index; the checksum byte yields a summary
// beat (kind 1) with header/checksum status. A bad second header byte still
// consumes the whole claimed frame. A good record-report frame (command 0x08,
// length >= 8) whose payload byte at offset 7 is data point 0x0B loads the
// last payload byte as the battery level when it differs, and flags it.
// Header, version, command and length bytes produce no result beat.
// Rate: one byte per clock while in_ready is high. The byte is parsed in the cycle
// it is accepted and its result is registered into a two-entry output buffer.
// in_ready drops only while both buffer entries hold results not yet taken.
module serial_frame_deframer_checksum (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  command,
    output logic [7:0]  version,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic [15:0] frame_length,
    output logic        frame_ok,
    output logic        header_bad,
    output logic        checksum_bad,
    output logic        battery_update,
    output logic [7:0]  battery_value
);

    logic              beat;
    logic              res_valid;
    sfdc_pkg::result_t res;
    sfdc_pkg::result_t out_data;

    assign beat = in_valid && in_ready;

    sfdc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // has_room is registered-count based, so in_ready never loops back
    // through out_ready
    sfdc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_room  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign command        = out_data.command;
    assign version        = out_data.version;
    assign payload_byte   = out_data.payload_byte;
    assign payload_index  = out_data.payload_index;
    assign frame_length   = out_data.frame_length;
    assign frame_ok       = out_data.frame_ok;
    assign header_bad     = out_data.header_bad;
    assign checksum_bad   = out_data.checksum_bad;
    assign battery_update = out_data.battery_update;
    assign battery_value  = out_data.battery_value;

endmodule
